/* hdl/tbs_pkg.sv */
// Shared types and constants for the token bucket shaper.
// Used by tbs_div, tbs_core and token_bucket_shaper; depends on nothing.
`default_nettype none

package tbs_pkg;

  localparam int TIME_FRAC_BITS = 16;
  localparam int TIME_W         = 48;
  localparam int LEN_W          = 16;
  localparam int CAP_W          = 16;
  localparam int RATE_W         = 32;
  localparam int FILL_FRAC      = 16;
  localparam int FILL_W         = 32;
  localparam int MUL_W          = 32;
  localparam int PROD_W         = 2 * MUL_W;
  localparam int DIV_W          = FILL_W + TIME_FRAC_BITS;
  localparam int CNT_W          = $clog2(DIV_W + 1);
  localparam int SUM_W          = ((DIV_W > TIME_W) ? DIV_W : TIME_W) + 1;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_INDEX_W    = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_BUCKET_CAPACITY = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_TOKEN_RATE      = CFG_INDEX_W'(1);

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(500);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(655360);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_REFILL,
    ST_DECIDE,
    ST_DIV,
    ST_DONE
  } tbs_state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [RATE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [TIME_W-1:0] dep;
    logic              delayed;
  } res_t;

endpackage

`default_nettype wire

/* hdl/tbs_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle, DIV_W quotient bits.
// Depends on tbs_pkg.
`default_nettype none

module tbs_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tbs_pkg::div_req_t req,
  output tbs_pkg::div_rsp_t      rsp
);
  import tbs_pkg::*;

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [FILL_W-1:0] rem;
  logic [DIV_W-1:0]  dq;
  logic [RATE_W-1:0] dvs;

  logic [FILL_W:0]   shifted;
  logic [FILL_W:0]   diff;
  logic              ge;

  always_comb begin
    shifted = {rem, dq[DIV_W-1]};
    ge      = shifted >= {1'b0, dvs};
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= CNT_W'(DIV_W);
      rem <= '0;
      dq  <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      // shift in the next dividend bit, keep the quotient bit at the bottom
      rem <= ge ? diff[FILL_W-1:0] : shifted[FILL_W-1:0];
      dq  <= {dq[DIV_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dq;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("divider started while busy");
  a_busy_cnt: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0) else $error("divider busy with empty count");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("divider done while busy");
`endif

endmodule

`default_nettype wire

/* hdl/tbs_core.sv */
// Shaper sequencer: backlog check, refill through a shared 32x32 multiplier,
// token decision and departure computation. Depends on tbs_pkg and tbs_div.
`default_nettype none

module tbs_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [tbs_pkg::TIME_W-1:0]  arrival_time,
  input  wire logic [tbs_pkg::LEN_W-1:0]   packet_length,
  input  wire logic [tbs_pkg::CAP_W-1:0]   cap,
  input  wire logic [tbs_pkg::RATE_W-1:0]  rate,
  output      logic                        res_valid,
  input  wire logic                        res_take,
  output      tbs_pkg::res_t               res
);
  import tbs_pkg::*;

  tbs_state_t state, state_next;

  logic                first_pending;
  logic [TIME_W-1:0]   last_dep;
  logic [FILL_W-1:0]   bucket_fill;

  logic [TIME_W-1:0]   arr;
  logic [LEN_W-1:0]    len;
  logic [TIME_W-1:0]   gap;
  logic [TIME_W-1:0]   base;
  logic [TIME_W-1:0]   dep;
  logic [FILL_W-1:0]   fill_w;
  logic [FILL_W-1:0]   part_hi;
  logic [PROD_W-1:0]   prod;

  logic [FILL_W-1:0]   len_q;
  logic [FILL_W-1:0]   cap_q;
  logic                backlog;
  logic [TIME_W-1:0]   gap_hi;
  logic                gap_ovf;
  logic [MUL_W-1:0]    mul_a;
  logic [PROD_W-1:0]   mul_out;
  logic [FILL_W:0]     tokens;
  logic [FILL_W-1:0]   room;
  logic                fits;
  logic [SUM_W-1:0]    sum;
  logic [TIME_W-1:0]   sat_dep;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tbs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    len_q   = {len, FILL_FRAC'(0)};
    cap_q   = {cap, FILL_FRAC'(0)};
    backlog = !first_pending && (last_dep > arr);
    gap_hi  = gap >> TIME_FRAC_BITS;
    gap_ovf = |gap_hi[TIME_W-1:MUL_W];
    mul_a   = (state == ST_MUL_HI) ? gap_hi[MUL_W-1:0]
                                   : {{(MUL_W-TIME_FRAC_BITS){1'b0}},
                                      gap[TIME_FRAC_BITS-1:0]};
    mul_out = PROD_W'(mul_a) * PROD_W'(rate);
    tokens  = {1'b0, part_hi} + {1'b0, prod[TIME_FRAC_BITS +: FILL_W]};
    room    = cap_q - bucket_fill;
    fits    = fill_w >= len_q;
    sum     = SUM_W'(base) + SUM_W'(div_rsp.quotient);
    sat_dep = (|sum[SUM_W-1:TIME_W]) ? '1 : sum[TIME_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_CHECK;
      ST_CHECK: begin
        if (backlog)            state_next = ST_DIV;
        else if (first_pending) state_next = ST_DECIDE;
        else                    state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        if (bucket_fill >= cap_q || gap_ovf) state_next = ST_DECIDE;
        else                                 state_next = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        if (prod >= PROD_W'(cap_q)) state_next = ST_DECIDE;
        else                        state_next = ST_REFILL;
      end
      ST_REFILL: state_next = ST_DECIDE;
      ST_DECIDE: state_next = fits ? ST_DONE : ST_DIV;
      ST_DIV:    if (div_rsp.done) state_next = ST_DONE;
      ST_DONE:   if (res_take) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready         = (state == ST_IDLE);
    res_valid        = (state == ST_DONE);
    res.dep          = dep;
    res.delayed      = dep > arr;
    div_req.start    = ((state == ST_CHECK) && backlog) ||
                       ((state == ST_DECIDE) && !fits);
    div_req.divisor  = rate;
    div_req.dividend = (state == ST_CHECK)
                       ? {len_q, TIME_FRAC_BITS'(0)}
                       : {len_q - fill_w, TIME_FRAC_BITS'(0)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      first_pending <= 1'b1;
      last_dep      <= '0;
      bucket_fill   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DECIDE) begin
        // shortfall drains the bucket
        bucket_fill <= fits ? fill_w - len_q : '0;
      end
      if (state == ST_DONE && res_take) begin
        last_dep      <= dep;
        first_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          arr <= arrival_time;
          len <= packet_length;
        end
      end
      ST_CHECK: begin
        gap    <= arr - last_dep;
        base   <= last_dep;
        fill_w <= cap_q;
      end
      ST_MUL_HI: begin
        fill_w <= cap_q;
        prod   <= mul_out;
      end
      ST_MUL_LO: begin
        fill_w  <= cap_q;
        part_hi <= prod[FILL_W-1:0];
        prod    <= mul_out;
      end
      ST_REFILL: begin
        fill_w <= (tokens >= {1'b0, room}) ? cap_q : bucket_fill + tokens[FILL_W-1:0];
      end
      ST_DECIDE: begin
        if (fits) dep  <= arr;
        else      base <= arr;
      end
      ST_DIV: begin
        if (div_rsp.done) dep <= sat_dep;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == ST_CHECK)
    else $error("accepted beat did not start a check");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_take) |=> res_valid && $stable(res.dep))
    else $error("pending result changed");
  a_first_clear: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_take) |=> !first_pending)
    else $error("first flag survived a result");
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> state == ST_DIV)
    else $error("divider started outside the divide path");
`endif

endmodule

`default_nettype wire

/* hdl/token_bucket_shaper.sv */
// Token bucket shaper top level: configuration registers, sequencer core and
// output register. Depends on tbs_pkg and tbs_core.
// A packet that leaves on arrival passes the check, the refill states if needed
// and the decision before out_valid (the refill path is the longest); when a
// delay is computed, the 48-step bit-serial divider sets the time to out_valid.
// One packet at a time; a new beat is taken the cycle after the previous
// result has moved to the output register.
// Reset (rst, synchronous): clears the shaper state, loads capacity 500 and
// rate 655360 (Q16.16), and empties the output register.
`default_nettype none

module token_bucket_shaper (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [tbs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tbs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire logic [tbs_pkg::TIME_W-1:0]      arrival_time,
  input  wire logic [tbs_pkg::LEN_W-1:0]       packet_length,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic [tbs_pkg::TIME_W-1:0]      departure_time,
  output      logic                            was_delayed
);
  import tbs_pkg::*;

  logic [CAP_W-1:0]  bucket_capacity;
  logic [RATE_W-1:0] token_rate;
  logic [RATE_W-1:0] eff_rate;
  logic              res_valid;
  logic              res_take;
  res_t              res;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_capacity <= CAP_RESET;
      token_rate      <= RATE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BUCKET_CAPACITY: bucket_capacity <= cfg_data[CAP_W-1:0];
        CFG_TOKEN_RATE:      token_rate      <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero rate counts as the smallest step
  assign eff_rate = (token_rate == '0) ? RATE_W'(1) : token_rate;

  tbs_core u_core (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .arrival_time  (arrival_time),
    .packet_length (packet_length),
    .cap           (bucket_capacity),
    .rate          (eff_rate),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res)
  );

  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      departure_time <= res.dep;
      was_delayed    <= res.delayed;
    end
  end

endmodule

`default_nettype wire
